FILE: rtl/core/fl_crc_pkg.sv
// Package: constants, types and CRC helpers for the four-lane CRC32C hash.
package fl_crc_pkg;

  localparam int unsigned BLOCK_BYTES = 32;
  localparam int unsigned BLOCK_AW    = $clog2(BLOCK_BYTES);
  localparam int unsigned LANE_BYTES  = BLOCK_BYTES / 4;
  localparam int unsigned SHORT_PAIR  = 16;
  localparam int unsigned LEN_W       = BLOCK_AW + 1;

  localparam logic [31:0] CRC_POLY    = 32'h82F6_3B78;
  localparam logic [31:0] START_RESET = 32'hFFFF_FFFF;
  localparam logic [4:0]  ROT3_RESET  = 5'd16;
  localparam logic [4:0]  ROT4_RESET  = 5'd8;

  // configuration register indexes
  localparam logic [1:0] CFG_START_VALUE = 2'd0;
  localparam logic [1:0] CFG_LANE3_ROT   = 2'd1;
  localparam logic [1:0] CFG_LANE4_ROT   = 2'd2;

  typedef enum logic [1:0] {
    S_RUN,
    S_PASS,
    S_MIX
  } fl_state_e;

  typedef logic [3:0][31:0] lanes_t;

  // per-cycle command from the sequencer to the lane registers
  typedef struct packed {
    logic       start;    // message start: lanes take the start value
    logic       upd;      // fold data into the selected lane
    logic       restore;  // working lanes back to the last block boundary
    logic       commit;   // block boundary: snapshot working lanes
    logic [1:0] lane;
    logic [7:0] data;
  } lane_ctl_t;

  // reflected CRC32C over one byte, no final inversion
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] r);
    logic [63:0] t;
    t = {x, x} << r;
    return t[63:32];
  endfunction

  // lane that byte idx of the tail pass goes to
  function automatic logic [1:0] tail_lane(input logic [LEN_W-1:0] idx,
                                           input logic [LEN_W-1:0] len,
                                           input logic             short_msg);
    logic [LEN_W-1:0] base;
    logic             pair;
    pair = (len >= LEN_W'(SHORT_PAIR));
    base = pair ? LEN_W'(SHORT_PAIR) : '0;
    if (!short_msg) begin
      return idx[BLOCK_AW-1 -: 2];
    end else if (pair && idx < LEN_W'(SHORT_PAIR)) begin
      return idx[BLOCK_AW-1 -: 2];
    end else if ((len - base) >= LEN_W'(LANE_BYTES) && idx < base + LEN_W'(LANE_BYTES)) begin
      return 2'd2;
    end else begin
      return 2'd3;
    end
  endfunction

endpackage

FILE: rtl/core/fl_crc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fl_crc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/fl_crc_lanes.sv
// Four CRC32C lane registers plus their snapshot at the last block boundary.
module fl_crc_lanes import fl_crc_pkg::*; (
  input  logic        clk_i,
  input  lane_ctl_t   ctl_i,
  input  logic [31:0] start_value_i,
  output lanes_t      lanes_o
);

  lanes_t      work_q, work_d;
  lanes_t      snap_q, snap_d;
  lanes_t      base, base_snap;
  logic [31:0] new_crc;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      base[k]      = ctl_i.start ? start_value_i : work_q[k];
      base_snap[k] = ctl_i.start ? start_value_i : snap_q[k];
    end
    new_crc = crc_byte(base[ctl_i.lane], ctl_i.data);
    for (int k = 0; k < 4; k++) begin
      if (ctl_i.restore) begin
        work_d[k] = base_snap[k];
      end else if (ctl_i.upd && ctl_i.lane == 2'(k)) begin
        work_d[k] = new_crc;
      end else begin
        work_d[k] = base[k];
      end
      snap_d[k] = ctl_i.commit ? work_d[k] : base_snap[k];
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    snap_q <= snap_d;
  end

  assign lanes_o = work_q;

endmodule

FILE: rtl/core/four_lane_crc32c_hash64.sv
// Top level: byte-stream four-lane CRC32C hash with 64-bit result.
//
// Usage
//   s_axis: one message byte per beat (tdata[7:0]); tlast marks the final
//   byte, tuser marks an empty message (tdata ignored, takes precedence).
//   m_axis: one 64-bit hash per message, tdata[31:0] = lane1 ^ rotl(lane3),
//   tdata[63:32] = lane2 ^ rotl(lane4).
//   cfg: write enable, index and data; start value, lane-3 and lane-4
//   rotate. Write only while no message is in flight.
// Throughput
//   One byte per cycle; the input stalls during the tail pass and mix.
//   Full 32-byte blocks are folded as they stream in. At the end of a
//   message a tail pass reads the 32-byte window RAM one byte per cycle
//   (one read port): all N bytes of a short message, the whole window for an
//   overlapping tail, none for a multiple of 32 bytes or an empty message.
// Reset and stall
//   Reset returns the sequencer to idle and clears the output beat; the
//   window RAM holds no reset state. A stalled output holds its beat while
//   the next message streams in; a second result waits for the slot.
module four_lane_crc32c_hash64 import fl_crc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  input  logic        s_axis_tuser,   // empty_message
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] hash_low, [63:32] hash_high
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  // config registers
  logic [31:0] start_q;
  logic [4:0]  rot3_q, rot4_q;

  // sequencer state
  fl_state_e              state_q, state_d;
  logic [BLOCK_AW-1:0]    pos_q, pos_d;       // window slot for next byte
  logic                   full_q, full_d;     // a whole block was folded
  logic [LEN_W-1:0]       cnt_q, cnt_d;       // tail pass read counter
  logic [LEN_W-1:0]       len_q, len_d;       // tail pass length
  logic [BLOCK_AW-1:0]    base_q, base_d;     // tail pass first slot
  logic                   short_q, short_d;   // short-message lane layout
  logic                   rd_vld_q, rd_vld_d;
  logic [1:0]             rd_lane_q, rd_lane_d;

  // output beat
  logic        out_vld_q, out_vld_d;
  logic [63:0] out_data_q, out_data_d;
  logic        out_free;

  // window RAM
  logic                ram_we;
  logic [BLOCK_AW-1:0] ram_raddr;
  logic [7:0]          ram_rdata;

  lane_ctl_t           ctl;
  lanes_t              lanes;
  logic                acc;
  logic [BLOCK_AW-1:0] pos_n;
  logic                blk_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= START_RESET;
      rot3_q  <= ROT3_RESET;
      rot4_q  <= ROT4_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_VALUE: start_q <= cfg_data_i;
        CFG_LANE3_ROT:   rot3_q  <= cfg_data_i[4:0];
        CFG_LANE4_ROT:   rot4_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_RUN);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign pos_n         = pos_q + 1'b1;
  assign blk_done      = (pos_q == BLOCK_AW'(BLOCK_BYTES - 1));
  assign ram_we        = acc && !s_axis_tuser;
  assign ram_raddr     = base_q + cnt_q[BLOCK_AW-1:0];

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    full_d     = full_q;
    cnt_d      = cnt_q;
    len_d      = len_q;
    base_d     = base_q;
    short_d    = short_q;
    rd_vld_d   = 1'b0;
    rd_lane_d  = rd_lane_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_data_d = out_data_q;
    ctl        = '0;
    ctl.data   = s_axis_tdata;
    ctl.lane   = pos_q[BLOCK_AW-1 -: 2];

    case (state_q)
      S_RUN: begin
        if (acc) begin
          if (s_axis_tuser) begin
            // empty message: all lanes hold the start value
            ctl.start = 1'b1;
            pos_d     = '0;
            full_d    = 1'b0;
            state_d   = S_MIX;
          end else begin
            ctl.start = (pos_q == '0) && !full_q;
            if (!s_axis_tlast || blk_done) begin
              ctl.upd    = 1'b1;
              ctl.commit = blk_done;
              pos_d      = pos_n;
              full_d     = full_q || blk_done;
              if (s_axis_tlast) begin
                pos_d   = '0;
                full_d  = 1'b0;
                state_d = S_MIX;
              end
            end else begin
              // tail: rewind lanes to the block boundary, replay the window
              ctl.restore = 1'b1;
              cnt_d       = '0;
              short_d     = !full_q;
              len_d       = full_q ? LEN_W'(BLOCK_BYTES) : {1'b0, pos_n};
              base_d      = full_q ? pos_n : '0;
              pos_d       = '0;
              full_d      = 1'b0;
              state_d     = S_PASS;
            end
          end
        end
      end
      S_PASS: begin
        ctl.upd  = rd_vld_q;
        ctl.lane = rd_lane_q;
        ctl.data = ram_rdata;
        if (cnt_q != len_q) begin
          rd_vld_d  = 1'b1;
          rd_lane_d = tail_lane(cnt_q, len_q, short_q);
          cnt_d     = cnt_q + 1'b1;
        end else begin
          state_d = S_MIX;
        end
      end
      S_MIX: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_data_d = {lanes[1] ^ rotl32(lanes[3], rot4_q),
                        lanes[0] ^ rotl32(lanes[2], rot3_q)};
          state_d    = S_RUN;
        end
      end
      default: state_d = S_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_RUN;
      pos_q     <= '0;
      full_q    <= 1'b0;
      cnt_q     <= '0;
      len_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      full_q    <= full_d;
      cnt_q     <= cnt_d;
      len_q     <= len_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    short_q    <= short_d;
    rd_lane_q  <= rd_lane_d;
    out_data_q <= out_data_d;
  end

  fl_crc_ram #(
    .WIDTH (8),
    .DEPTH (BLOCK_BYTES)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q),
    .wdata_i (s_axis_tdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  fl_crc_lanes u_lanes (
    .clk_i         (clk_i),
    .ctl_i         (ctl),
    .start_value_i (start_q),
    .lanes_o       (lanes)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // read data only returns during a tail pass
  a_rd_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> state_q == S_PASS)
    else $error("window read data outside tail pass");

  // pass length is one to a full block, counter never overruns it
  a_pass_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PASS |-> (len_q != '0) && (len_q <= LEN_W'(BLOCK_BYTES)) && (cnt_q <= len_q))
    else $error("tail pass length out of range");

  // finished pass always proceeds to the mix
  a_pass_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PASS) && (cnt_q == len_q) |=> state_q == S_MIX)
    else $error("tail pass did not reach mix");

  // a pending result is never overwritten by a new one
  a_no_clobber: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MIX) && out_vld_q && !m_axis_tready |=> state_q == S_MIX)
    else $error("result produced while output slot busy");

endmodule
